[hdl/sequenced_packet_block_assembler_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sequenced packet block assembler
// Shared property templates for the checker.
// ---------------------------------------------------------------------------
`ifndef SEQUENCED_PACKET_BLOCK_ASSEMBLER_DEFINES_SVH
`define SEQUENCED_PACKET_BLOCK_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SPBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/spba_pkg.sv]
// ---------------------------------------------------------------------------
// spba_pkg
// Widths, codes and shared types of the sequenced packet block assembler.
// ---------------------------------------------------------------------------
package spba_pkg;

  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned BLK_IDX_W  = 32;
  localparam int unsigned SLOT_W     = 14;
  localparam int unsigned CNT_W      = 15;
  localparam int unsigned CFG_W      = 15;
  localparam int unsigned POS_W      = 16;  // holds three block lengths
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam int unsigned MAX_PACKETS_PER_BLOCK = 16384;
  localparam int unsigned PAYLOAD_BYTES         = 8192;
  localparam int unsigned DEFAULT_BLOCK_BYTES   = 75497472;

  localparam logic [CFG_W-1:0] PPB_RESET = CFG_W'(DEFAULT_BLOCK_BYTES / PAYLOAD_BYTES);
  localparam logic [CNT_W-1:0] SIZE_MAX  = CNT_W'(MAX_PACKETS_PER_BLOCK);
  localparam logic [CNT_W-1:0] SIZE_MIN  = CNT_W'(1);

  localparam logic [REG_IDX_W-1:0] REG_IDX_PPB = REG_IDX_W'(0);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_STORE_CUR     = 3'd0,
    ACT_STORE_NEXT    = 3'd1,
    ACT_FLUSH_STORE   = 3'd2,
    ACT_FLUSH_DISCARD = 3'd3,
    ACT_LATE          = 3'd4,
    ACT_BAD_LEN       = 3'd5,
    ACT_TERMINATE     = 3'd6,
    ACT_AFTER_END     = 3'd7
  } action_e;

  // Classification done at the front; only PLACE needs the block state.
  typedef enum logic [1:0] {
    KIND_PLACE,
    KIND_BAD_LEN,
    KIND_TERMINATE,
    KIND_AFTER_END
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [SEQ_W-1:0] seq_m1;
  } queue_entry_t;

  typedef struct packed {
    action_e              action;
    logic                 buffer_select;
    logic [SLOT_W-1:0]    slot_index;
    logic                 flush_buffer;
    logic [CNT_W-1:0]     missing_count;
    logic [BLK_IDX_W-1:0] flushed_block;
  } result_t;

endpackage

[hdl/spba_if.sv]
// ---------------------------------------------------------------------------
// spba_in_if / spba_out_if
// Valid/ready channels for packet descriptors and placement results.
// ---------------------------------------------------------------------------
interface spba_in_if import spba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] sequence_number;
  logic             length_ok;
  logic             empty_packet;

  modport source (output valid, sequence_number, length_ok, empty_packet, input ready);
  modport sink   (input valid, sequence_number, length_ok, empty_packet, output ready);
endinterface

interface spba_out_if import spba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  action_e              action;
  logic                 buffer_select;
  logic [SLOT_W-1:0]    slot_index;
  logic                 flush_buffer;
  logic [CNT_W-1:0]     missing_count;
  logic [BLK_IDX_W-1:0] flushed_block;

  modport source (output valid, action, buffer_select, slot_index, flush_buffer,
                  missing_count, flushed_block, input ready);
  modport sink   (input valid, action, buffer_select, slot_index, flush_buffer,
                  missing_count, flushed_block, output ready);
endinterface

[hdl/sequenced_packet_block_assembler.sv]
// ---------------------------------------------------------------------------
// sequenced_packet_block_assembler
// Ping-pong reorder control: places packet descriptors into two block buffers.
// ---------------------------------------------------------------------------
//  channel   direction  kind         carries
//  pkt_i     in         valid/ready  sequence_number, length_ok, empty_packet
//  res_o     out        valid/ready  action, buffer_select, slot_index,
//                                    flush_buffer, missing_count, flushed_block
//  APB       in/out     psel/penable packets_per_block at byte address 0
//
//  One transaction per cycle sustained while res_o is not stalled. Each
//  descriptor is classified on input accept and written into the queue;
//  block bookkeeping then writes its result into the output register. The
//  rate is set by the base subtract and compares in the back stage, which
//  updates block state for the next transaction.
//  Reset is asynchronous and active low.
//  A stalled result holds the back stage; the two-entry queue then fills and
//  drops pkt_i.ready while the output still waits.
// ---------------------------------------------------------------------------
module sequenced_packet_block_assembler import spba_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  spba_in_if.sink               pkt_i,
  spba_out_if.source            res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration register: slots per block.
  logic [CFG_W-1:0]     ppb_q, ppb_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  // Front to queue, queue to back.
  logic         push_valid, push_ready;
  queue_entry_t push_entry;
  logic         q_valid, q_pop;
  queue_entry_t q_entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Take the write only for a known register; drop the rest.
  always_comb begin
    ppb_d = ppb_q;
    if (cfg_wr && (reg_idx == REG_IDX_PPB)) begin
      ppb_d = pwdata[CFG_W-1:0];
    end
  end

  // Return the register on read; unmapped addresses read zero.
  always_comb begin
    if (reg_idx == REG_IDX_PPB) begin
      prdata = APB_DATA_W'(ppb_q);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppb_q <= PPB_RESET;
    end else begin
      ppb_q <= ppb_d;
    end
  end

  // Front: accept and classify, track end of stream.
  spba_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pkt_i        (pkt_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  // Queue: let front and back stall independently.
  spba_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_entry_i (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (q_valid),
    .pop_entry_o  (q_entry),
    .pop_i        (q_pop)
  );

  // Back: block bookkeeping and registered result.
  spba_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ppb_i     (ppb_q),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

[hdl/spba_front.sv]
// ---------------------------------------------------------------------------
// spba_front
// Accepts descriptors, tracks end of stream and classifies each transaction.
// ---------------------------------------------------------------------------
module spba_front import spba_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  spba_in_if.sink      pkt_i,
  output logic         push_valid_o,
  output queue_entry_t push_entry_o,
  input  logic         push_ready_i
);

  logic  ended_q, ended_d;
  kind_e kind;
  logic  accept;

  always_comb begin
    priority if (ended_q) begin
      kind = KIND_AFTER_END;
    end else if ((pkt_i.sequence_number == '0) || pkt_i.empty_packet) begin
      kind = KIND_TERMINATE;
    end else if (!pkt_i.length_ok) begin
      kind = KIND_BAD_LEN;
    end else begin
      kind = KIND_PLACE;
    end
  end

  assign accept             = pkt_i.valid && push_ready_i;
  assign pkt_i.ready        = push_ready_i;
  assign push_valid_o       = pkt_i.valid;
  assign push_entry_o.kind  = kind;
  assign push_entry_o.seq_m1 = pkt_i.sequence_number - SEQ_W'(1);

  // Latch end of stream once a terminating descriptor goes through.
  assign ended_d = ended_q || (accept && (kind == KIND_TERMINATE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q <= 1'b0;
    end else begin
      ended_q <= ended_d;
    end
  end

endmodule

[hdl/spba_fifo.sv]
// ---------------------------------------------------------------------------
// spba_fifo
// Short queue between classification and block bookkeeping.
// ---------------------------------------------------------------------------
module spba_fifo import spba_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  input  queue_entry_t push_entry_i,
  output logic         push_ready_o,
  output logic         pop_valid_o,
  output queue_entry_t pop_entry_o,
  input  logic         pop_i
);

  queue_entry_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]         cnt_q, cnt_d;
  logic                      push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_entry_o  = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

[hdl/spba_back.sv]
// ---------------------------------------------------------------------------
// spba_back
// Holds block base, ping-pong roles and arrival counts; decides placement.
// ---------------------------------------------------------------------------
module spba_back import spba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] ppb_i,
  input  logic             q_valid_i,
  input  queue_entry_t     q_entry_i,
  output logic             q_pop_o,
  spba_out_if.source       res_o
);

  logic [SEQ_W-1:0]     base_q, base_d;
  logic [BLK_IDX_W-1:0] blk_idx_q, blk_idx_d;
  logic                 cur_buf_q, cur_buf_d;
  logic [CNT_W-1:0]     cur_cnt_q, cur_cnt_d;
  logic [CNT_W-1:0]     nxt_cnt_q, nxt_cnt_d;
  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;

  logic [CNT_W-1:0]     n;
  logic [SEQ_W:0]       diff;
  logic                 late, hi_zero;
  logic [POS_W-1:0]     pos_lo, n1, n2, n3;
  logic                 in_cur, in_nxt, in_new;
  logic [CNT_W-1:0]     cur_bump, nxt_bump, missing;
  logic                 fire;

  // Clamp the block length into 1..max.
  always_comb begin
    priority if (ppb_i == '0) begin
      n = SIZE_MIN;
    end else if (ppb_i > SIZE_MAX) begin
      n = SIZE_MAX;
    end else begin
      n = ppb_i;
    end
  end

  assign diff    = {1'b0, q_entry_i.seq_m1} - {1'b0, base_q};
  assign late    = diff[SEQ_W];
  assign hi_zero = (diff[SEQ_W-1:POS_W] == '0);
  assign pos_lo  = diff[POS_W-1:0];
  assign n1      = POS_W'(n);
  assign n2      = n1 << 1;
  assign n3      = n2 + n1;
  assign in_cur  = hi_zero && (pos_lo < n1);
  assign in_nxt  = hi_zero && (pos_lo < n2);
  assign in_new  = hi_zero && (pos_lo < n3);

  assign cur_bump = (cur_cnt_q < n) ? cur_cnt_q + CNT_W'(1) : n;
  assign nxt_bump = (nxt_cnt_q < n) ? nxt_cnt_q + CNT_W'(1) : n;
  assign missing  = (cur_cnt_q >= n) ? '0 : n - cur_cnt_q;

  assign fire    = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = fire;

  always_comb begin
    base_d    = base_q;
    blk_idx_d = blk_idx_q;
    cur_buf_d = cur_buf_q;
    cur_cnt_d = cur_cnt_q;
    nxt_cnt_d = nxt_cnt_q;
    res_d     = '0;
    unique case (q_entry_i.kind)
      KIND_AFTER_END: res_d.action = ACT_AFTER_END;
      KIND_TERMINATE: res_d.action = ACT_TERMINATE;
      KIND_BAD_LEN:   res_d.action = ACT_BAD_LEN;
      KIND_PLACE: begin
        priority if (late) begin
          res_d.action = ACT_LATE;
        end else if (in_cur) begin
          res_d.action        = ACT_STORE_CUR;
          res_d.buffer_select = cur_buf_q;
          res_d.slot_index    = SLOT_W'(pos_lo);
          cur_cnt_d           = cur_bump;
        end else if (in_nxt) begin
          res_d.action        = ACT_STORE_NEXT;
          res_d.buffer_select = ~cur_buf_q;
          res_d.slot_index    = SLOT_W'(pos_lo - n1);
          nxt_cnt_d           = nxt_bump;
        end else begin
          // Flush the current block and advance by exactly one block.
          res_d.flush_buffer  = cur_buf_q;
          res_d.missing_count = missing;
          res_d.flushed_block = blk_idx_q;
          cur_buf_d           = ~cur_buf_q;
          cur_cnt_d           = nxt_cnt_q;
          blk_idx_d           = blk_idx_q + BLK_IDX_W'(1);
          base_d              = base_q + SEQ_W'(n);
          if (in_new) begin
            res_d.action        = ACT_FLUSH_STORE;
            res_d.buffer_select = cur_buf_q;
            res_d.slot_index    = SLOT_W'(pos_lo - n2);
            nxt_cnt_d           = CNT_W'(1);
          end else begin
            res_d.action        = ACT_FLUSH_DISCARD;
            nxt_cnt_d           = '0;
          end
        end
      end
      default: res_d.action = ACT_AFTER_END;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      blk_idx_q   <= '0;
      cur_buf_q   <= 1'b0;
      cur_cnt_q   <= '0;
      nxt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        base_q    <= base_d;
        blk_idx_q <= blk_idx_d;
        cur_buf_q <= cur_buf_d;
        cur_cnt_q <= cur_cnt_d;
        nxt_cnt_q <= nxt_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.action        = res_q.action;
  assign res_o.buffer_select = res_q.buffer_select;
  assign res_o.slot_index    = res_q.slot_index;
  assign res_o.flush_buffer  = res_q.flush_buffer;
  assign res_o.missing_count = res_q.missing_count;
  assign res_o.flushed_block = res_q.flushed_block;

endmodule

[hdl/spba_checker.sv]
// ---------------------------------------------------------------------------
// spba_checker
// Port-level checks on the result channel of the block assembler.
// ---------------------------------------------------------------------------
`include "sequenced_packet_block_assembler_defines.svh"

module spba_checker import spba_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 res_valid_i,
  input logic                 res_ready_i,
  input action_e              res_action_i,
  input logic [SLOT_W-1:0]    res_slot_index_i,
  input logic [CNT_W-1:0]     res_missing_count_i,
  input logic [BLK_IDX_W-1:0] res_flushed_block_i
);

  logic                 seen_term_q;
  logic [BLK_IDX_W-1:0] next_flush_q;
  logic                 res_acc, is_flush;

  assign res_acc  = res_valid_i && res_ready_i;
  assign is_flush = (res_action_i == ACT_FLUSH_STORE) || (res_action_i == ACT_FLUSH_DISCARD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_term_q  <= 1'b0;
      next_flush_q <= '0;
    end else begin
      if (res_acc && (res_action_i == ACT_TERMINATE)) begin
        seen_term_q <= 1'b1;
      end
      if (res_acc && is_flush) begin
        next_flush_q <= next_flush_q + BLK_IDX_W'(1);
      end
    end
  end

  `SPBA_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i,
    res_valid_i && $stable(res_action_i) && $stable(res_slot_index_i)
      && $stable(res_flushed_block_i), "result changed while stalled")
  `SPBA_ASSERT_IMP(a_after_end_only, clk_i, rst_ni, res_valid_i && seen_term_q,
    res_action_i == ACT_AFTER_END, "result other than after-end past termination")
  `SPBA_ASSERT_IMP(a_after_end_cause, clk_i, rst_ni,
    res_valid_i && (res_action_i == ACT_AFTER_END), seen_term_q,
    "after-end result without a prior termination")
  `SPBA_ASSERT_IMP(a_flush_order, clk_i, rst_ni, res_valid_i && is_flush,
    res_flushed_block_i == next_flush_q, "flushed block index out of order")
  `SPBA_ASSERT_IMP(a_no_flush_fields, clk_i, rst_ni, res_valid_i && !is_flush,
    (res_missing_count_i == '0) && (res_flushed_block_i == '0),
    "flush fields set on a non-flush result")

endmodule

bind sequenced_packet_block_assembler spba_checker u_spba_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .res_action_i        (res_o.action),
  .res_slot_index_i    (res_o.slot_index),
  .res_missing_count_i (res_o.missing_count),
  .res_flushed_block_i (res_o.flushed_block)
);
